### src/gsa_pkg.sv
package gsa_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int GEN_W = 32;
  localparam int OWNER_W = 64;
  localparam int IDX_IN_W = 6;
  localparam int CNT_OUT_W = 7;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;

  localparam int IN_FIELDS_W = IDX_IN_W + GEN_W + OWNER_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = IDX_IN_W + GEN_W + CNT_OUT_W + CNT_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CHECK   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic ready;
    logic clear_wr;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

### src/gsa_ram.sv
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/gsa_ctrl.sv
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  dp_status_t sts,
  output ctrl_cmd_t  ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_CLEAR: ctl.clear_wr = 1'b1;
      ST_IDLE: begin
        ctl.ready  = 1'b1;
        ctl.accept = s_tvalid;
      end
      ST_EXEC: ctl.exec = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

### src/gsa_dpath.sv
module gsa_dpath
  import gsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              ctl,
  output dp_status_t             sts,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [CMD_W-1:0]       s_tuser,
  input  logic                   cfg_wr_en,
  input  logic [OWNER_W-1:0]     cfg_wr_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]    m_tuser
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENT_W = 1 + GEN_W + LINK_W;
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  // entry layout: occupied, generation, link
  logic [OWNER_W-1:0] token;
  cmd_t               cmd_q;
  logic [GEN_W-1:0]   gen_q;
  logic [OWNER_W-1:0] owner_q;
  logic               in_range_q;
  logic [IDX_W-1:0]   addr_q;
  logic [LINK_W-1:0]  head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   peak;
  logic [IDX_W-1:0]   clr_cnt;

  logic [IDX_IN_W-1:0] in_idx;
  logic [GEN_W-1:0]    in_gen;
  logic [OWNER_W-1:0]  in_owner;
  cmd_t                in_cmd;
  logic [31:0]         in_idx_w;
  logic                in_range;
  logic                head_ok;
  logic [IDX_W-1:0]    rd_addr;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic [ENT_W-1:0]   rd_data;
  logic               rd_occ;
  logic [GEN_W-1:0]   rd_gen;
  logic [LINK_W-1:0]  rd_link;

  logic               handle_ok;
  logic [LINK_W-1:0]  head_next;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   count_inc;
  logic [CNT_W-1:0]   peak_next;
  status_t            status;
  logic [IDX_IN_W-1:0] g_idx;
  logic [GEN_W-1:0]   g_gen;
  logic               ex_wr;
  logic [ENT_W-1:0]   ex_data;

  assign in_idx   = s_tdata[IDX_IN_W-1:0];
  assign in_gen   = s_tdata[IDX_IN_W +: GEN_W];
  assign in_owner = s_tdata[IDX_IN_W+GEN_W +: OWNER_W];
  assign in_cmd   = cmd_t'(s_tuser);
  assign in_idx_w = 32'(in_idx);
  assign in_range = in_idx_w < 32'(SLOTS);
  assign head_ok  = head < LINK_END;

  always_comb begin
    rd_addr = '0;
    if (in_cmd == CMD_ALLOC) begin
      if (head_ok) begin
        rd_addr = head[IDX_W-1:0];
      end
    end else if (in_range) begin
      rd_addr = in_idx_w[IDX_W-1:0];
    end
  end

  assign rd_occ  = rd_data[ENT_W-1];
  assign rd_gen  = rd_data[LINK_W +: GEN_W];
  assign rd_link = rd_data[LINK_W-1:0];

  assign handle_ok = (owner_q != '0) && (owner_q == token) && in_range_q && rd_occ
                     && (rd_gen == gen_q);
  assign count_inc = count + CNT_W'(1);

  always_comb begin
    head_next  = head;
    count_next = count;
    peak_next  = peak;
    status     = STATUS_BAD;
    g_idx      = '0;
    g_gen      = '0;
    ex_wr      = 1'b0;
    ex_data    = rd_data;
    case (cmd_q)
      CMD_ALLOC: begin
        if (!head_ok) begin
          status = STATUS_FULL;
        end else begin
          status     = STATUS_OK;
          head_next  = (rd_link > LINK_END) ? LINK_END : rd_link;
          count_next = count_inc;
          if (count_inc > peak) begin
            peak_next = count_inc;
          end
          g_idx   = IDX_IN_W'(head);
          g_gen   = rd_gen;
          ex_wr   = 1'b1;
          ex_data = {1'b1, rd_gen, rd_link};
        end
      end
      CMD_RELEASE: begin
        if (handle_ok) begin
          status     = STATUS_OK;
          count_next = count - CNT_W'(1);
          ex_wr      = 1'b1;
          if (rd_gen == GEN_MAX) begin
            // retired: kept off the free list
            ex_data = {1'b0, rd_gen, rd_link};
          end else begin
            ex_data   = {1'b0, rd_gen + GEN_W'(1), head};
            head_next = LINK_W'(addr_q);
          end
        end
      end
      CMD_CHECK: begin
        if (handle_ok) begin
          status = STATUS_OK;
        end
      end
      default: status = STATUS_BAD;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = ex_data;
    if (ctl.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = {1'b0, GEN_W'(0), LINK_W'(clr_cnt) + LINK_W'(1)};
    end else if (ctl.exec) begin
      wr_en = ex_wr;
    end
  end

  gsa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign sts.clear_last = (clr_cnt == IDX_LAST);
  assign sts.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      token    <= OWNER_W'(1);
      head     <= '0;
      count    <= '0;
      peak     <= '0;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        token <= cfg_wr_data;
      end
      if (ctl.clear_wr) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (ctl.exec) begin
        head     <= head_next;
        count    <= count_next;
        peak     <= peak_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q      <= in_cmd;
      gen_q      <= in_gen;
      owner_q    <= in_owner;
      in_range_q <= in_range;
      addr_q     <= rd_addr;
    end
    if (ctl.exec) begin
      m_tuser <= status;
      m_tdata <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), CNT_OUT_W'(peak_next),
                  CNT_OUT_W'(count_next), g_gen, g_idx};
    end
  end

endmodule

### src/generational_slot_allocator.sv
// channel  dir  tdata (low bit up)                                 tuser     tlast
// s_*      in   slot_index[6], handle_generation[32],              command   -
//               handle_owner[64], zero pad to 104
// m_*      out  granted_index[6], granted_generation[32],          status    -
//               live_count[7], high_water[7], zero pad to 56
// cfg_*    in   owner_token[64] on cfg_wr_data when cfg_wr_en      -         -
//
// a command is accepted in ST_IDLE, whose accept cycle issues the slot entry read from the
// single-port-read slot ram; ST_EXEC then checks it and writes the entry back.
// after reset a clearing pass writes every slot entry and rebuilds the free list;
// s_tready stays low during it.
// the output register lets a new command be accepted while a result waits;
// the write-back cycle holds while that register is still full.
module generational_slot_allocator
  import gsa_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // slot_index, handle_generation, handle_owner
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // command
  input  logic [CMD_W-1:0]       s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // granted_index, granted_generation, live_count, high_water
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic [STATUS_W-1:0]    m_tuser,
  input  logic                   cfg_wr_en,
  input  logic [OWNER_W-1:0]     cfg_wr_data
);

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  assign s_tready = ctl.ready;

  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .ctl      (ctl)
  );

  gsa_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

### verif/tb_generational_slot_allocator.sv
module tb_generational_slot_allocator;
  import gsa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int GG_LO = IDX_IN_W;
  localparam int LC_LO = GG_LO + GEN_W;
  localparam int HW_LO = LC_LO + CNT_OUT_W;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_IN_W-1:0] idx;
    logic [GEN_W-1:0]    gen;
    logic [OWNER_W-1:0]  owner;
  } handle_cmd_t;

  typedef struct {
    status_t              status;
    logic [IDX_IN_W-1:0]  granted_idx;
    logic [GEN_W-1:0]     granted_gen;
    logic [CNT_OUT_W-1:0] live;
    logic [CNT_OUT_W-1:0] peak;
  } pool_result_t;

  class slot_pool_scoreboard;
    logic [OWNER_W-1:0]   owner_token;
    logic [CNT_OUT_W-1:0] next_link [SLOTS_DEF];
    logic [GEN_W-1:0]     slot_gen [SLOTS_DEF];
    bit                   occupied [SLOTS_DEF];
    bit                   retired [SLOTS_DEF];
    logic [CNT_OUT_W-1:0] free_head;
    logic [CNT_OUT_W-1:0] live;
    logic [CNT_OUT_W-1:0] peak;
    pool_result_t         pending_results [$];
    int                   errors;
    int                   checked;
    int                   full_seen;
    int                   bad_seen;

    function new();
      owner_token = 64'd1;
      for (int i = 0; i < SLOTS_DEF; i++) begin
        next_link[i] = CNT_OUT_W'(i + 1);
        slot_gen[i] = '0;
        occupied[i] = 1'b0;
        retired[i] = 1'b0;
      end
      free_head = '0;
      live = '0;
      peak = '0;
      errors = 0;
      checked = 0;
      full_seen = 0;
      bad_seen = 0;
    endfunction

    function bit handle_valid(logic [IDX_IN_W-1:0] idx, logic [GEN_W-1:0] gen,
                              logic [OWNER_W-1:0] owner);
      return owner != '0 && owner == owner_token && occupied[idx] && slot_gen[idx] == gen;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [IDX_IN_W-1:0] idx,
                               logic [GEN_W-1:0] gen, logic [OWNER_W-1:0] owner);
      pool_result_t r;
      logic [IDX_IN_W-1:0] s;
      r.status = STATUS_BAD;
      r.granted_idx = '0;
      r.granted_gen = '0;
      case (cmd)
        CMD_ALLOC: begin
          if (free_head >= SLOTS_DEF) begin
            r.status = STATUS_FULL;
          end else begin
            s = free_head[IDX_IN_W-1:0];
            free_head = next_link[s];
            if (free_head > SLOTS_DEF) free_head = CNT_OUT_W'(SLOTS_DEF);
            occupied[s] = 1'b1;
            live = live + 1'b1;
            if (live > peak) peak = live;
            r.status = STATUS_OK;
            r.granted_idx = s;
            r.granted_gen = slot_gen[s];
          end
        end
        CMD_RELEASE: begin
          if (handle_valid(idx, gen, owner)) begin
            occupied[idx] = 1'b0;
            live = live - 1'b1;
            if (slot_gen[idx] == GEN_MAX) begin
              retired[idx] = 1'b1;
            end else begin
              slot_gen[idx] = slot_gen[idx] + 1'b1;
              next_link[idx] = free_head;
              free_head = {1'b0, idx};
            end
            r.status = STATUS_OK;
          end
        end
        CMD_CHECK: begin
          if (handle_valid(idx, gen, owner)) r.status = STATUS_OK;
        end
        default: ;
      endcase
      r.live = live;
      r.peak = peak;
      if (r.status == STATUS_FULL) full_seen++;
      if (r.status == STATUS_BAD) bad_seen++;
      pending_results = {pending_results, r};
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [IDX_IN_W-1:0] granted_idx,
                      logic [GEN_W-1:0] granted_gen, logic [CNT_OUT_W-1:0] live_count,
                      logic [CNT_OUT_W-1:0] high_water);
      pool_result_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no command pending");
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      if (status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
      if (granted_idx !== exp.granted_idx)
        report_mismatch($sformatf("granted_index %0d, expected %0d",
                                  granted_idx, exp.granted_idx));
      if (granted_gen !== exp.granted_gen)
        report_mismatch($sformatf("granted_generation %0h, expected %0h",
                                  granted_gen, exp.granted_gen));
      if (live_count !== exp.live)
        report_mismatch($sformatf("live_count %0d, expected %0d", live_count, exp.live));
      if (high_water !== exp.peak)
        report_mismatch($sformatf("high_water %0d, expected %0d", high_water, exp.peak));
    endtask
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [OWNER_W-1:0]     cfg_wr_data = '0;

  slot_pool_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;

  generational_slot_allocator uut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_result(m_tuser, m_tdata[IDX_IN_W-1:0], m_tdata[LC_LO-1:GG_LO],
                        m_tdata[HW_LO-1:LC_LO], m_tdata[HW_LO+CNT_OUT_W-1:HW_LO]);
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_IN_W-1:0] idx,
                           input logic [GEN_W-1:0] gen, input logic [OWNER_W-1:0] owner);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= IN_TDATA_W'({owner, gen, idx});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(cmd, idx, gen, owner);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_owner(input logic [OWNER_W-1:0] token);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= token;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.owner_token = token;
  endtask

  // allocs at alloc_pct, else mostly live handles taken from the pool state, the rest stale, foreign or junk
  function automatic handle_cmd_t pick_command(int alloc_pct);
    handle_cmd_t it;
    int occ [$];
    int r;
    int k;
    it.cmd = CMD_ALLOC;
    it.idx = IDX_IN_W'($urandom);
    it.gen = $urandom;
    it.owner = {$urandom, $urandom};
    for (int i = 0; i < SLOTS_DEF; i++)
      if (sb.occupied[i]) occ = {occ, i};
    k = (occ.size() > 0) ? occ[$urandom_range(occ.size() - 1)] : $urandom_range(SLOTS_DEF - 1);
    r = $urandom_range(99);
    if (r < alloc_pct) begin
      it.cmd = CMD_ALLOC;
    end else if (r < alloc_pct + (100 - alloc_pct) * 4 / 5 && occ.size() > 0) begin
      it.cmd = ($urandom_range(2) != 0) ? CMD_RELEASE : CMD_CHECK;
      it.idx = IDX_IN_W'(k);
      it.gen = sb.slot_gen[k];
      it.owner = sb.owner_token;
    end else begin
      it.cmd = $urandom_range(1) ? CMD_RELEASE : CMD_CHECK;
      it.idx = IDX_IN_W'(k);
      it.gen = sb.slot_gen[k];
      it.owner = sb.owner_token;
      case ($urandom_range(4))
        0: it.gen = $urandom_range(1) ? sb.slot_gen[k] - 1'b1 : sb.slot_gen[k] + 1'b1;
        1: it.owner = sb.owner_token ^ (64'd1 << $urandom_range(OWNER_W - 1));
        2: it.owner = '0;
        3: begin
          it.cmd = CMD_UNUSED;
          it.idx = IDX_IN_W'($urandom);
          it.gen = $urandom;
          it.owner = {$urandom, $urandom};
        end
        default: begin
          it.idx = IDX_IN_W'($urandom);
          it.gen = $urandom;
          it.owner = $urandom_range(1) ? sb.owner_token : {$urandom, $urandom};
        end
      endcase
    end
    return it;
  endfunction

  task automatic run_phase(input logic [OWNER_W-1:0] token, input int count,
                           input int alloc_pct, input int send_idle, input int recv_stall);
    handle_cmd_t it;
    wait_drained();
    write_owner(token);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    repeat (count) begin
      it = pick_command(alloc_pct);
      send_item(it.cmd, it.idx, it.gen, it.owner);
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_owner('1);

    // directed handles against the all-ones owner token
    send_item(CMD_CHECK, 6'd0, 32'd0, '1);
    send_item(CMD_ALLOC, 6'h3f, '1, '1);
    send_item(CMD_CHECK, 6'd0, 32'd0, '1);
    send_item(CMD_CHECK, 6'd0, 32'd0, '0);
    send_item(CMD_CHECK, 6'd0, 32'd0, 64'hffff_ffff_ffff_fffe);
    send_item(CMD_CHECK, 6'd0, '1, '1);
    send_item(CMD_CHECK, 6'h3f, 32'd0, '1);
    send_item(CMD_ALLOC, 6'd0, 32'd0, '0);
    send_item(CMD_RELEASE, 6'd0, 32'd0, '1);
    send_item(CMD_RELEASE, 6'd0, 32'd0, '1);
    send_item(CMD_CHECK, 6'd0, 32'd0, '1);
    send_item(CMD_ALLOC, 6'd0, 32'd0, '0);
    send_item(CMD_UNUSED, '1, '1, '1);
    send_item(CMD_UNUSED, 6'd0, 32'd0, '0);
    send_item(CMD_RELEASE, 6'd1, 32'd0, '1);
    send_item(CMD_RELEASE, 6'd0, 32'd1, '0);
    send_item(CMD_RELEASE, 6'd0, 32'd1, '1);
    send_item(CMD_CHECK, 6'h2a, 32'haaaa_aaaa, 64'h5555_5555_5555_5555);

    run_phase(64'd1, 200, 75, 0, 0);
    run_phase({$urandom, $urandom}, 200, 35, 55, 0);
    run_phase('0, 60, 50, 0, 55);
    run_phase('1, 200, 25, 24, 24);
    run_phase({$urandom, $urandom}, 180, 55, 0, 0);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("checked %0d commands over six owner-token settings and four flow-control mixes",
             sb.checked);
    $display("saw %0d pool-full and %0d rejected-handle results, high-water %0d of %0d slots",
             sb.full_seen, sb.bad_seen, sb.peak, SLOTS_DEF);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/gsa_pkg.sv
src/gsa_ram.sv
src/gsa_ctrl.sv
src/gsa_dpath.sv
src/generational_slot_allocator.sv
verif/tb_generational_slot_allocator.sv
